@@ rtl/fspa_pkg.sv @@
package fspa_pkg;

    // Pool geometry
    localparam int MAX_SLOTS = 64;
    localparam int IDX_W     = $clog2(MAX_SLOTS);
    localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
    localparam int ADDR_W    = 32;
    localparam int BYTES_W   = 16;
    localparam int PROD_W    = IDX_W + BYTES_W;
    localparam int STEP_W    = $clog2(ADDR_W);
    localparam int CFG_IDX_W = 2;

    // Register reset values
    localparam logic [CNT_W-1:0]   RST_SLOT_COUNT  = CNT_W'(MAX_SLOTS);
    localparam logic [BYTES_W-1:0] RST_SLOT_BYTES  = BYTES_W'(16);
    localparam logic [ADDR_W-1:0]  RST_REGION_BASE = '0;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SLOT_COUNT  = 2'd0,
        CFG_SLOT_BYTES  = 2'd1,
        CFG_REGION_BASE = 2'd2
    } t_cfg_idx;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_BAD_ADDR = 2'd2,
        ST_NOT_USED = 2'd3
    } t_status;

    // Clamp the programmed slot count into 1..MAX_SLOTS
    function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] cnt);
        logic [CNT_W-1:0] res;
        if (cnt == '0) begin
            res = CNT_W'(1);
        end else if (cnt > CNT_W'(MAX_SLOTS)) begin
            res = CNT_W'(MAX_SLOTS);
        end else begin
            res = cnt;
        end
        return res;
    endfunction

    // A zero slot size acts as one byte
    function automatic logic [BYTES_W-1:0] eff_bytes(input logic [BYTES_W-1:0] b);
        return (b == '0) ? BYTES_W'(1) : b;
    endfunction

endpackage

@@ rtl/fixed_slot_pool_allocator.sv @@
// Fixed-size slot pool allocator, lowest free slot first.
//
// Input channel: i_in_valid / o_in_stall carry one word of i_action and
// i_address. Action 0 acquires the lowest free slot, action 1 releases the
// slot whose byte address is given. Output channel: o_out_valid / i_out_stall
// carry one result word per input word: status, slot index, slot address,
// free count, lowest free index and the saturating exhaustion count.
// From accept to result: an acquire goes through S_SCAN, which steps over
// the busy slots above the one handed out, then S_FINISH; a release runs
// the radix-2 divider that turns the offset into a slot index one quotient
// bit per cycle while no configuration write holds it, then S_CHECK and
// S_FINISH; a full pool or a null or below-base release goes straight to
// S_FINISH. One word is in flight at a time, and the next word is taken
// only after a result loads and the block is back in S_IDLE.
// The result sits in an output register, so the block takes the next input
// word while an earlier result still waits to be taken; a stalled result
// holds until the receiver takes it, and a finished result waits behind it.
// Reset (synchronous, active low) restores 64 slots of 16 bytes at base 0
// and frees every slot. A write to a known register frees every slot too
// and clears the lowest free index and the exhaustion count.
module fixed_slot_pool_allocator
    import fspa_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ADDR_W-1:0]    i_cfg_data,
    // input channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_action,
    input  logic [ADDR_W-1:0]    i_address,
    // output channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [1:0]           o_status,
    output logic [IDX_W-1:0]     o_slot_index,
    output logic [ADDR_W-1:0]    o_slot_address,
    output logic [CNT_W-1:0]     o_free_count,
    output logic [CNT_W-1:0]     o_lowest_free,
    output logic [ADDR_W-1:0]    o_exhaust_count
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DIV,
        S_CHECK,
        S_FINISH
    } t_state;

    t_state              r_state;

    // configuration
    logic [CNT_W-1:0]    r_slot_count;
    logic [BYTES_W-1:0]  r_slot_bytes;
    logic [ADDR_W-1:0]   r_region_base;

    // pool state
    logic [MAX_SLOTS-1:0] r_busy;
    logic [CNT_W-1:0]    r_free;
    logic [CNT_W-1:0]    r_lowest;
    logic [ADDR_W-1:0]   r_exhaust;

    // per-word working registers
    logic [CNT_W-1:0]    r_scan;
    logic [PROD_W-1:0]   r_prod;
    logic [ADDR_W-1:0]   r_quo;
    logic [BYTES_W-1:0]  r_rem;
    logic [STEP_W-1:0]   r_step;
    t_status             r_res_status;
    logic [IDX_W-1:0]    r_res_idx;
    logic [ADDR_W-1:0]   r_res_addr;

    // output register
    logic                r_out_valid;
    t_status             r_out_status;
    logic [IDX_W-1:0]    r_out_idx;
    logic [ADDR_W-1:0]   r_out_addr;
    logic [CNT_W-1:0]    r_out_free;
    logic [CNT_W-1:0]    r_out_lowest;
    logic [ADDR_W-1:0]   r_out_exhaust;

    logic [CNT_W-1:0]    cnt_eff;
    logic [BYTES_W-1:0]  size_eff;
    logic                in_take;
    logic                out_free;
    logic                cfg_hit;
    logic                out_load;
    logic [ADDR_W-1:0]   rel_off;
    logic [IDX_W-1:0]    rel_slot;
    logic [BYTES_W:0]    div_try;
    logic [BYTES_W:0]    div_diff;
    logic                div_ge;
    logic [BYTES_W-1:0]  n_rem;
    logic [ADDR_W-1:0]   n_quo;
    logic [CNT_W-1:0]    n_cfg_count;

    assign cnt_eff  = eff_count(r_slot_count);
    assign size_eff = eff_bytes(r_slot_bytes);
    assign in_take  = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;
    assign rel_off  = i_address - r_region_base;
    assign rel_slot = r_quo[IDX_W-1:0];

    // A write to a known register restarts the pool
    assign cfg_hit  = i_cfg_we && (i_cfg_idx == CFG_SLOT_COUNT ||
                                   i_cfg_idx == CFG_SLOT_BYTES ||
                                   i_cfg_idx == CFG_REGION_BASE);
    assign out_load = !cfg_hit && (r_state == S_FINISH) && out_free;

    // Slot count that the pool restarts with after a configuration write
    assign n_cfg_count = (i_cfg_idx == CFG_SLOT_COUNT) ?
                         eff_count(i_cfg_data[CNT_W-1:0]) : cnt_eff;

    // Restoring divider step: bring in the next offset bit, subtract if it fits
    always_comb begin
        div_try  = {r_rem, r_quo[ADDR_W-1]};
        div_diff = div_try - {1'b0, size_eff};
        div_ge   = (div_try >= {1'b0, size_eff});
        n_rem    = div_ge ? div_diff[BYTES_W-1:0] : div_try[BYTES_W-1:0];
        n_quo    = {r_quo[ADDR_W-2:0], div_ge};
    end

    // Sequencer, pool state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_slot_count  <= RST_SLOT_COUNT;
            r_slot_bytes  <= RST_SLOT_BYTES;
            r_region_base <= RST_REGION_BASE;
            r_busy        <= '0;
            r_free        <= eff_count(RST_SLOT_COUNT);
            r_lowest      <= '0;
            r_exhaust     <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            // load a result word, or drop it once the receiver takes it
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (cfg_hit) begin
                // write a register and restart the pool
                unique case (i_cfg_idx)
                    CFG_SLOT_COUNT:  r_slot_count  <= i_cfg_data[CNT_W-1:0];
                    CFG_SLOT_BYTES:  r_slot_bytes  <= i_cfg_data[BYTES_W-1:0];
                    CFG_REGION_BASE: r_region_base <= i_cfg_data;
                    default:         r_region_base <= r_region_base;
                endcase
                r_busy    <= '0;
                r_free    <= n_cfg_count;
                r_lowest  <= '0;
                r_exhaust <= '0;
            end else begin
                unique case (r_state)
                    S_IDLE: begin
                        if (in_take) begin
                            r_res_addr <= '0;
                            if (!i_action) begin
                                if (r_free == '0 || r_lowest >= cnt_eff) begin
                                    // refuse: pool exhausted
                                    r_res_idx    <= '0;
                                    r_res_status <= ST_FULL;
                                    if (r_exhaust != '1) begin
                                        r_exhaust <= r_exhaust + 1'b1;
                                    end
                                    r_state <= S_FINISH;
                                end else begin
                                    // hand out the lowest free slot
                                    r_busy[r_lowest[IDX_W-1:0]] <= 1'b1;
                                    r_free       <= r_free - 1'b1;
                                    r_res_idx    <= r_lowest[IDX_W-1:0];
                                    r_res_status <= ST_OK;
                                    r_prod       <= r_lowest[IDX_W-1:0] * size_eff;
                                    r_scan       <= r_lowest + 1'b1;
                                    r_state      <= S_SCAN;
                                end
                            end else begin
                                r_res_idx <= '0;
                                if (i_address == '0 || i_address < r_region_base) begin
                                    r_res_status <= ST_BAD_ADDR;
                                    r_state      <= S_FINISH;
                                end else begin
                                    // start dividing the offset by the slot size
                                    r_quo   <= rel_off;
                                    r_rem   <= '0;
                                    r_step  <= '0;
                                    r_state <= S_DIV;
                                end
                            end
                        end
                    end
                    S_SCAN: begin
                        // step over busy slots, one per cycle while no configuration write holds the sequencer
                        if (r_scan < cnt_eff && r_busy[r_scan[IDX_W-1:0]]) begin
                            r_scan <= r_scan + 1'b1;
                        end else begin
                            r_lowest   <= r_scan;
                            r_res_addr <= r_region_base + ADDR_W'(r_prod);
                            r_state    <= S_FINISH;
                        end
                    end
                    S_DIV: begin
                        r_quo  <= n_quo;
                        r_rem  <= n_rem;
                        r_step <= r_step + 1'b1;
                        if (r_step == STEP_W'(ADDR_W - 1)) begin
                            r_state <= S_CHECK;
                        end
                    end
                    S_CHECK: begin
                        if (r_quo >= ADDR_W'(cnt_eff) || r_rem != '0) begin
                            r_res_status <= ST_BAD_ADDR;
                        end else if (!r_busy[rel_slot]) begin
                            r_res_status <= ST_NOT_USED;
                        end else begin
                            // free the slot and pull the lowest free index down
                            r_busy[rel_slot] <= 1'b0;
                            r_free           <= r_free + 1'b1;
                            if (CNT_W'(rel_slot) < r_lowest) begin
                                r_lowest <= CNT_W'(rel_slot);
                            end
                            r_res_idx    <= rel_slot;
                            r_res_status <= ST_OK;
                        end
                        r_state <= S_FINISH;
                    end
                    S_FINISH: begin
                        // load the result word once the output register is free
                        if (out_free) begin
                            r_out_status  <= r_res_status;
                            r_out_idx     <= r_res_idx;
                            r_out_addr    <= r_res_addr;
                            r_out_free    <= r_free;
                            r_out_lowest  <= r_lowest;
                            r_out_exhaust <= r_exhaust;
                            r_state       <= S_IDLE;
                        end
                    end
                    default: r_state <= S_IDLE;
                endcase
            end
        end
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_slot_index    = r_out_idx;
    assign o_slot_address  = r_out_addr;
    assign o_free_count    = r_out_free;
    assign o_lowest_free   = r_out_lowest;
    assign o_exhaust_count = r_out_exhaust;

endmodule

@@ rtl/fspa_checker.sv @@
module fspa_checker
    import fspa_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 o_in_stall,
    input  logic                 o_out_valid,
    input  logic                 i_out_stall,
    input  logic [1:0]           o_status,
    input  logic [IDX_W-1:0]     o_slot_index,
    input  logic [ADDR_W-1:0]    o_slot_address,
    input  logic [CNT_W-1:0]     o_free_count,
    input  logic [CNT_W-1:0]     o_lowest_free
);

    // Reset empties the output register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result word valid after reset");

    // A stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status) &&
            $stable(o_slot_index) && $stable(o_slot_address))
        else $error("stalled result word changed");

    // One word in flight: the block is busy right after it takes a word
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken twice in a row");

    // Refused words carry no slot
    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_OK |-> o_slot_index == '0 && o_slot_address == '0)
        else $error("refused word carries a slot");

    // Counts stay within the pool
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_free_count <= CNT_W'(MAX_SLOTS) &&
            o_lowest_free <= CNT_W'(MAX_SLOTS))
        else $error("free count or lowest free index out of range");

endmodule

bind fixed_slot_pool_allocator fspa_checker u_fspa_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_status       (o_status),
    .o_slot_index   (o_slot_index),
    .o_slot_address (o_slot_address),
    .o_free_count   (o_free_count),
    .o_lowest_free  (o_lowest_free)
);

@@ verif/tb_top.sv @@
module tb_top;
    import fspa_pkg::*;

    localparam logic                 ACT_ACQUIRE    = 1'b0;
    localparam logic                 ACT_RELEASE    = 1'b1;
    // index 3 decodes to no register
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED     = 2'd3;
    localparam int                   WATCHDOG_LIMIT = 2000;
    localparam int                   END_WAIT       = 80;
    localparam int                   HOLD_AT        = 250;
    localparam int                   HOLD_CYCLES    = 400;
    localparam int                   RAND_PHASES    = 8;
    localparam int                   PHASE_WORDS    = 100;
    localparam int                   DIR_ROWS       = 27;

    typedef struct packed {
        t_status             status;
        logic [IDX_W-1:0]    slot;
        logic [ADDR_W-1:0]   addr;
        logic [CNT_W-1:0]    free_cnt;
        logic [CNT_W-1:0]    low;
        logic [ADDR_W-1:0]   exhaust;
    } pool_reply_t;

    typedef struct {
        bit          typed;
        pool_reply_t reply;
    } typed_note_t;

    typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

    // code carries the action for a word row, the register index for a config row
    typedef struct {
        row_kind_t           kind;
        logic [1:0]          code;
        logic [ADDR_W-1:0]   data;
        bit                  typed;
        pool_reply_t         reply;
    } dir_row_t;

    localparam pool_reply_t NO_REPLY = '{ST_OK, '0, '0, '0, '0, '0};

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [ADDR_W-1:0]    i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic                 i_action;
    logic [ADDR_W-1:0]    i_address;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [1:0]           o_status;
    logic [IDX_W-1:0]     o_slot_index;
    logic [ADDR_W-1:0]    o_slot_address;
    logic [CNT_W-1:0]     o_free_count;
    logic [CNT_W-1:0]     o_lowest_free;
    logic [ADDR_W-1:0]    o_exhaust_count;

    fixed_slot_pool_allocator dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_action        (i_action),
        .i_address       (i_address),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_slot_index    (o_slot_index),
        .o_slot_address  (o_slot_address),
        .o_free_count    (o_free_count),
        .o_lowest_free   (o_lowest_free),
        .o_exhaust_count (o_exhaust_count)
    );

    // Shadow copy of the pool and its registers
    logic [MAX_SLOTS-1:0] pool_busy;
    logic [CNT_W-1:0]     pool_free;
    logic [CNT_W-1:0]     pool_low;
    logic [ADDR_W-1:0]    pool_exhaust;
    logic [CNT_W-1:0]     cfg_count;
    logic [BYTES_W-1:0]   cfg_bytes;
    logic [ADDR_W-1:0]    cfg_base;

    pool_reply_t replies_due[$];
    typed_note_t typed_due[$];
    int          mismatches = 0;
    int          quiet_cycles = 0;
    dir_row_t    dir_plan [DIR_ROWS];

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int unsigned slots_in_use();
        return (cfg_count == '0) ? 1 : ((cfg_count > MAX_SLOTS) ? MAX_SLOTS : cfg_count);
    endfunction

    function automatic int unsigned bytes_per_slot();
        return (cfg_bytes == '0) ? 1 : cfg_bytes;
    endfunction

    // Byte address of a slot, wrapped to the address width
    function automatic logic [ADDR_W-1:0] slot_base_addr(input int unsigned slot);
        logic [ADDR_W-1:0] a;
        a = cfg_base + ADDR_W'(slot * bytes_per_slot());
        return a;
    endfunction

    function automatic void clear_pool();
        pool_busy    = '0;
        pool_free    = CNT_W'(slots_in_use());
        pool_low     = '0;
        pool_exhaust = '0;
    endfunction

    function automatic void write_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [ADDR_W-1:0] data);
        case (idx)
            CFG_SLOT_COUNT:  cfg_count = data[CNT_W-1:0];
            CFG_SLOT_BYTES:  cfg_bytes = data[BYTES_W-1:0];
            CFG_REGION_BASE: cfg_base  = data;
            default:         return;
        endcase
        clear_pool();
    endfunction

    // Apply one acquire or release to the shadow pool and return the reply
    function automatic pool_reply_t allocator_reply(input logic act,
                                                    input logic [ADDR_W-1:0] address);
        pool_reply_t       r;
        int unsigned       cnt;
        int unsigned       size;
        int unsigned       slot;
        int unsigned       nxt;
        longint unsigned   a;
        longint unsigned   off;
        cnt = slots_in_use();
        size = bytes_per_slot();
        r = NO_REPLY;
        if (act == ACT_ACQUIRE) begin
            if (pool_free == '0 || pool_low >= cnt) begin
                r.status = ST_FULL;
                if (pool_exhaust != '1) begin
                    pool_exhaust++;
                end
            end else begin
                slot = pool_low;
                nxt = slot + 1;
                while (nxt < cnt && pool_busy[nxt]) begin
                    nxt++;
                end
                pool_busy[slot] = 1'b1;
                pool_free--;
                pool_low = CNT_W'(nxt);
                r.slot = IDX_W'(slot);
                r.addr = slot_base_addr(slot);
            end
        end else begin
            a = address;
            if (a == 0 || a < cfg_base) begin
                r.status = ST_BAD_ADDR;
            end else begin
                off = a - cfg_base;
                if (off >= longint'(cnt) * size || off % size != 0) begin
                    r.status = ST_BAD_ADDR;
                end else begin
                    slot = int'(off / size);
                    if (!pool_busy[slot]) begin
                        r.status = ST_NOT_USED;
                    end else begin
                        pool_busy[slot] = 1'b0;
                        pool_free++;
                        if (slot < pool_low) begin
                            pool_low = CNT_W'(slot);
                        end
                        r.slot = IDX_W'(slot);
                    end
                end
            end
        end
        r.free_cnt = pool_free;
        r.low      = pool_low;
        r.exhaust  = pool_exhaust;
        return r;
    endfunction

    function automatic void check_reply(input pool_reply_t want, input pool_reply_t got);
        if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            mismatches++;
        end
        if (got.slot !== want.slot) begin
            $error("slot_index: expected %0d, got %0d", want.slot, got.slot);
            mismatches++;
        end
        if (got.addr !== want.addr) begin
            $error("slot_address: expected %08h, got %08h", want.addr, got.addr);
            mismatches++;
        end
        if (got.free_cnt !== want.free_cnt) begin
            $error("free_count: expected %0d, got %0d", want.free_cnt, got.free_cnt);
            mismatches++;
        end
        if (got.low !== want.low) begin
            $error("lowest_free: expected %0d, got %0d", want.low, got.low);
            mismatches++;
        end
        if (got.exhaust !== want.exhaust) begin
            $error("exhaust_count: expected %0d, got %0d", want.exhaust, got.exhaust);
            mismatches++;
        end
    endfunction

    // Track register writes and accepted words, check each result word
    always @(posedge i_clk) begin
        pool_reply_t want;
        pool_reply_t got;
        typed_note_t note;
        if (!i_rst_n) begin
            cfg_count = CNT_W'(MAX_SLOTS);
            cfg_bytes = BYTES_W'(16);
            cfg_base  = '0;
            clear_pool();
        end else begin
            if (i_cfg_we) begin
                write_register(i_cfg_idx, i_cfg_data);
            end
            if (i_in_valid && !o_in_stall) begin
                want = allocator_reply(i_action, i_address);
                note = typed_due.pop_front();
                if (note.typed) begin
                    want = note.reply;
                end
                replies_due.push_back(want);
            end
            if (o_out_valid && !i_out_stall) begin
                got.status   = t_status'(o_status);
                got.slot     = o_slot_index;
                got.addr     = o_slot_address;
                got.free_cnt = o_free_count;
                got.low      = o_lowest_free;
                got.exhaust  = o_exhaust_count;
                if (replies_due.size() == 0) begin
                    $error("result word with no word pending, status %0d", o_status);
                    mismatches++;
                end else begin
                    check_reply(replies_due.pop_front(), got);
                end
            end
        end
    end

    // End the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Idle gap per word, with occasional back-to-back stretches
    function automatic int draw_gap(inout int burst);
        if (burst > 0) begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            burst = $urandom_range(8, 30);
            return 0;
        end
        return $urandom_range(0, 10);
    endfunction

    // Result side: stall a random number of cycles before each word, hold off long once
    initial begin : result_side
        int gap;
        int burst;
        int taken;
        i_out_stall = 1'b0;
        burst = 0;
        taken = 0;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            gap = draw_gap(burst);
            taken++;
            if (taken == HOLD_AT) begin
                gap = HOLD_CYCLES;
            end
            if (gap > 0) begin
                i_out_stall <= 1'b1;
                repeat (gap) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            @(negedge i_clk);
        end
    end

    int send_burst = 0;

    // Offer one word after a random gap and hold it until taken
    task automatic offer_word(input logic act, input logic [ADDR_W-1:0] address,
                              input bit typed, input pool_reply_t reply);
        int gap;
        gap = draw_gap(send_burst);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        typed_due.push_back('{typed, reply});
        i_action   <= act;
        i_address  <= address;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (replies_due.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] data);
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        i_cfg_we   <= 1'b1;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Pick a random word: mostly acquires and releases of live slots, some bad addresses
    function automatic void choose_word(input int acq_share, output logic act,
                                        output logic [ADDR_W-1:0] address);
        int unsigned cnt;
        int unsigned size;
        int          roll;
        int          busy_list[$];
        int          free_list[$];
        cnt = slots_in_use();
        size = bytes_per_slot();
        for (int i = 0; i < cnt; i++) begin
            if (pool_busy[i]) begin
                busy_list.push_back(i);
            end else begin
                free_list.push_back(i);
            end
        end
        act = ACT_RELEASE;
        address = $urandom();
        roll = $urandom_range(0, 99);
        if (roll < acq_share) begin
            act = ACT_ACQUIRE;
            return;
        end
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
            if (busy_list.size() == 0) begin
                act = ACT_ACQUIRE;
            end else begin
                address = slot_base_addr(busy_list[$urandom_range(0, busy_list.size() - 1)]);
            end
        end else if (roll < 80) begin
            if (free_list.size() == 0) begin
                address = slot_base_addr($urandom_range(0, cnt - 1));
            end else begin
                address = slot_base_addr(free_list[$urandom_range(0, free_list.size() - 1)]);
            end
        end else if (roll < 87) begin
            address = slot_base_addr($urandom_range(0, cnt - 1));
            if (size > 1) begin
                address = address + ADDR_W'($urandom_range(1, size - 1));
            end
        end else if (roll < 93) begin
            address = slot_base_addr(cnt + $urandom_range(0, 3));
        end else if (roll < 96) begin
            address = '0;
        end
    endfunction

    initial begin : stimulus
        logic              act;
        logic [ADDR_W-1:0] address;
        int                roll;
        int                acq_share;
        logic [ADDR_W-1:0] value;

        dir_plan = '{
            // reset geometry: 64 slots of 16 bytes at base 0
            '{ROW_WORD, ACT_ACQUIRE, 32'h0, 1'b1, '{ST_OK, 6'd0, 32'h0, 7'd63, 7'd1, 32'd0}},
            '{ROW_WORD, ACT_RELEASE, 32'h0, 1'b1,
              '{ST_BAD_ADDR, 6'd0, 32'h0, 7'd63, 7'd1, 32'd0}},
            '{ROW_WORD, ACT_ACQUIRE, 32'h0, 1'b0, NO_REPLY},
            '{ROW_WORD, ACT_RELEASE, 32'd16, 1'b0, NO_REPLY},
            // double free
            '{ROW_WORD, ACT_RELEASE, 32'd16, 1'b1,
              '{ST_NOT_USED, 6'd0, 32'h0, 7'd63, 7'd1, 32'd0}},
            '{ROW_WORD, ACT_RELEASE, 32'd8, 1'b0, NO_REPLY},
            '{ROW_WORD, ACT_RELEASE, 32'd1024, 1'b0, NO_REPLY},
            // a write to no register leaves the pool alone
            '{ROW_CFG, CFG_UNUSED, 32'hFFFF_FFFF, 1'b0, NO_REPLY},
            '{ROW_WORD, ACT_RELEASE, 32'hFFFF_FFFF, 1'b0, NO_REPLY},
            // zero count and zero size act as one, upper data bits dropped
            '{ROW_CFG, CFG_SLOT_COUNT, 32'hFFFF_FF80, 1'b0, NO_REPLY},
            '{ROW_CFG, CFG_SLOT_BYTES, 32'hFFFF_0000, 1'b0, NO_REPLY},
            '{ROW_CFG, CFG_REGION_BASE, 32'd5, 1'b0, NO_REPLY},
            '{ROW_WORD, ACT_ACQUIRE, 32'h0, 1'b1, '{ST_OK, 6'd0, 32'd5, 7'd0, 7'd1, 32'd0}},
            '{ROW_WORD, ACT_ACQUIRE, 32'h0, 1'b1, '{ST_FULL, 6'd0, 32'h0, 7'd0, 7'd1, 32'd1}},
            '{ROW_WORD, ACT_ACQUIRE, 32'h0, 1'b1, '{ST_FULL, 6'd0, 32'h0, 7'd0, 7'd1, 32'd2}},
            '{ROW_WORD, ACT_RELEASE, 32'd4, 1'b0, NO_REPLY},
            '{ROW_WORD, ACT_RELEASE, 32'd6, 1'b0, NO_REPLY},
            '{ROW_WORD, ACT_RELEASE, 32'd5, 1'b1, '{ST_OK, 6'd0, 32'h0, 7'd1, 7'd0, 32'd2}},
            '{ROW_WORD, ACT_ACQUIRE, 32'h0, 1'b0, NO_REPLY},
            // count above the maximum, largest size, base near the top so addresses wrap
            '{ROW_CFG, CFG_SLOT_COUNT, 32'h7F, 1'b0, NO_REPLY},
            '{ROW_CFG, CFG_SLOT_BYTES, 32'hFFFF, 1'b0, NO_REPLY},
            '{ROW_CFG, CFG_REGION_BASE, 32'hFFFF_FFF0, 1'b0, NO_REPLY},
            '{ROW_WORD, ACT_ACQUIRE, 32'h0, 1'b1,
              '{ST_OK, 6'd0, 32'hFFFF_FFF0, 7'd63, 7'd1, 32'd0}},
            '{ROW_WORD, ACT_ACQUIRE, 32'h0, 1'b0, NO_REPLY},
            '{ROW_WORD, ACT_RELEASE, 32'h0000_FFEF, 1'b0, NO_REPLY},
            '{ROW_WORD, ACT_RELEASE, 32'hFFFF_FFF0, 1'b1,
              '{ST_OK, 6'd0, 32'h0, 7'd63, 7'd0, 32'd0}},
            '{ROW_WORD, ACT_ACQUIRE, 32'h0, 1'b0, NO_REPLY}
        };

        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = CFG_SLOT_COUNT;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_action    = ACT_ACQUIRE;
        i_address   = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Walk the directed rows
        foreach (dir_plan[r]) begin
            if (dir_plan[r].kind == ROW_CFG) begin
                wait_drained();
                write_cfg(dir_plan[r].code, dir_plan[r].data);
            end else begin
                offer_word(dir_plan[r].code[0], dir_plan[r].data, dir_plan[r].typed,
                           dir_plan[r].reply);
            end
        end

        // Random phases, each under a fresh geometry
        for (int p = 0; p < RAND_PHASES; p++) begin
            wait_drained();
            roll = $urandom_range(0, 19);
            if (roll < 8) value = $urandom_range(1, 8);
            else if (roll < 12) value = MAX_SLOTS;
            else if (roll < 15) value = $urandom_range(9, MAX_SLOTS - 1);
            else if (roll < 17) value = $urandom_range(MAX_SLOTS + 1, 127);
            else if (roll < 18) value = 0;
            else value = $urandom_range(0, 127);
            write_cfg(CFG_SLOT_COUNT, ($urandom() & ~32'h7F) | value);
            roll = $urandom_range(0, 7);
            if (roll == 0) value = 0;
            else if (roll == 1) value = 1;
            else if (roll == 2) value = 1 << $urandom_range(1, 15);
            else if (roll == 3) value = 32'h0000_FFFF;
            else if (roll == 6) value = $urandom_range(0, 32'h0000_FFFF);
            else value = $urandom_range(2, 64);
            write_cfg(CFG_SLOT_BYTES, ($urandom() & ~32'hFFFF) | value);
            roll = $urandom_range(0, 3);
            if (roll == 0) value = 0;
            else if (roll == 1) value = $urandom();
            else if (roll == 2) value = 32'hFFFF_FFFF - $urandom_range(0, 4096);
            else value = $urandom_range(1, 4096);
            write_cfg(CFG_REGION_BASE, value);
            acq_share = $urandom_range(35, 80);
            for (int n = 0; n < PHASE_WORDS; n++) begin
                choose_word(acq_share, act, address);
                offer_word(act, address, 1'b0, NO_REPLY);
            end
        end

        // Drain and let the pipeline settle
        wait_drained();
        repeat (END_WAIT) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/fspa_pkg.sv
rtl/fixed_slot_pool_allocator.sv
rtl/fspa_checker.sv
verif/tb_top.sv
